// ===== rtl/rrqd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqd_pkg
// Types and constants shared by the round-robin quantum dispatcher.
// ----------------------------------------------------------------------------
package rrqd_pkg;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;

    // op codes
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd10;

    typedef struct packed {
        logic               op;
        logic [ID_W-1:0]    task_id;
        logic [BURST_W-1:0] burst;
    } t_in;

    typedef struct packed {
        logic               rejected;
        logic               idle;
        logic [ID_W-1:0]    granted_id;
        logic [BURST_W-1:0] run_time;
        logic               finished;
    } t_out;

    // one queue slot: task id and its remaining burst
    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [BURST_W-1:0] remaining;
    } t_entry;

endpackage

// ===== rtl/rrqd_ram.sv =====
// ----------------------------------------------------------------------------
// rrqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrqd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/round_robin_quantum_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_quantum_dispatcher_unit
// Round-robin task dispatcher: circular task queue in RAM, quantum-limited
// grants, requeue or retire after each dispatch.
// ----------------------------------------------------------------------------
// An add, or a dispatch that finds the queue empty, gives its result in the cycle
//   after acceptance; a dispatch of a queued task first registers the queue RAM read
//   data, then the registered grant. Adds are taken one item per cycle while busy is
//   low; a queued dispatch holds busy during the RAM read, so no new item is accepted.
// Reset: synchronous, active low; empties the queue, quantum back to 10.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
module round_robin_quantum_dispatcher_unit #(
    parameter int MAX_TASKS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    input  rrqd_pkg::t_in                  i_cmd,
    output logic                           busy,
    // quantum register
    input  logic                           i_cfg_we,
    input  logic [rrqd_pkg::BURST_W-1:0]   i_cfg_wdata,
    // result strobe
    output logic                           o_valid,
    output rrqd_pkg::t_out                 o_result
);

    import rrqd_pkg::*;

    localparam int PTR_W   = $clog2(MAX_TASKS);
    localparam int OCC_W   = $clog2(MAX_TASKS + 1);
    localparam int ENTRY_W = $bits(t_entry);

    // control state
    logic                r_pend;     // dispatch waiting on RAM read data
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [BURST_W-1:0]  r_quantum;
    logic                r_valid, n_valid;
    t_out                r_result, n_result;

    // datapath
    logic                accept, is_add, full, empty;
    logic                push_new, requeue, ram_we, ram_re;
    t_entry              rd_entry, wr_entry;
    logic [BURST_W-1:0]  grant, rem_left;

    assign accept = start && !busy;
    assign is_add = (i_cmd.op == OP_ADD);
    assign full   = (r_occ == OCC_W'(MAX_TASKS));
    assign empty  = (r_occ == '0);

    // grant is the smaller of quantum and remaining burst
    assign grant    = (r_quantum < rd_entry.remaining) ? r_quantum : rd_entry.remaining;
    assign rem_left = rd_entry.remaining - grant;

    // a task with burst left goes back to the tail; head slot is freed first,
    // so the requeue always fits
    assign requeue  = r_pend && (rem_left != '0);
    assign push_new = accept && is_add && !full;
    assign ram_we   = push_new || requeue;
    assign ram_re   = accept && (i_cmd.op == OP_DISPATCH) && !empty;

    always_comb begin
        if (r_pend) begin
            wr_entry.task_id   = rd_entry.task_id;
            wr_entry.remaining = rem_left;
        end else begin
            wr_entry.task_id   = i_cmd.task_id;
            wr_entry.remaining = i_cmd.burst;
        end
    end

    rrqd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (rd_entry)
    );

    // pointer and occupancy update
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (r_pend) begin
            n_head = (r_head == PTR_W'(MAX_TASKS - 1)) ? '0 : r_head + PTR_W'(1);
        end
        if (ram_we) begin
            n_tail = (r_tail == PTR_W'(MAX_TASKS - 1)) ? '0 : r_tail + PTR_W'(1);
        end
        if (push_new) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (r_pend && !requeue) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    // result formation
    always_comb begin
        n_result = '0;
        n_valid  = 1'b0;
        if (r_pend) begin
            n_valid             = 1'b1;
            n_result.granted_id = rd_entry.task_id;
            n_result.run_time   = grant;
            n_result.finished   = !requeue;
        end else if (accept && is_add) begin
            n_valid           = 1'b1;
            n_result.rejected = full;
        end else if (accept && empty) begin
            n_valid       = 1'b1;
            n_result.idle = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_quantum <= QUANTUM_RESET;
            r_valid   <= 1'b0;
        end else begin
            r_pend  <= ram_re;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
        end
    end

    // result payload, qualified by r_valid
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = r_pend;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/rrqd_checker.sv =====
// ----------------------------------------------------------------------------
// rrqd_checker
// Port-level checks on the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module rrqd_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           o_valid,
    input  rrqd_pkg::t_out o_result
);

    // busy lasts one cycle and ends with the dispatch result
    a_busy_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("busy not followed by a result");

    // an accepted item yields a result next cycle or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted item made no progress");

    // no result without a cause
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result without an accepted item");

    // status flags are mutually exclusive
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_result.rejected, o_result.idle, o_result.finished}))
        else $error("conflicting result flags");

    // rejected or idle results carry no grant
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.rejected || o_result.idle)) |->
            (o_result.granted_id == '0 && o_result.run_time == '0))
        else $error("grant fields set on a non-dispatch result");

endmodule

bind round_robin_quantum_dispatcher_unit rrqd_checker u_rrqd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
